/* hw/rtl/daf_pkg.sv */
package daf_pkg;

    // ASCII code of the character '0', six bits wide like the result field.
    localparam logic [5:0] ASCII_ZERO = 6'd48;

    // Largest number of digit cells a 32-bit value can need.
    localparam int DIGIT_CAP = 10;

    // Mode codes carried on s_cmd.
    localparam logic MODE_INT  = 1'b0;
    localparam logic MODE_FRAC = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_EMIT
    } daf_state_t;

    // Per-cycle command to every digit cell of the chain.
    typedef struct packed {
        logic clear;      // zero the digit
        logic dbl;        // double dabble step: adjust, shift left, take a bit
        logic dig_shift;  // take the whole digit of the lower neighbor
    } daf_cell_ctrl_t;

endpackage

/* hw/rtl/decimal_ascii_formatter.sv */
// Decimal ASCII formatter.
//
// The input channel (s_valid, s_ready, s_cmd, s_value) takes one 32-bit
// unsigned value per beat. s_cmd low prints the value as an integer, where
// zero prints a single '0'. s_cmd high prints fraction digits, left-padded
// with '0' characters up to the width held in the fraction width register.
// The result channel (m_valid, m_ready, m_ascii_char, m_last) carries one
// ASCII digit per beat, most significant first, with m_last on the final one.
// The width register holds 3 after reset and takes cfg_wr_data on cfg_wr_en;
// the user must write it only while idle; the block does not enforce this.
//
// An accepted item passes through serial double dabble in the row of digit
// cells, one value bit per cycle, then a scan that strips leading zero cells
// (every cell for a zero value) and settles the counts, then emission of
// the characters while m_ready is high or no character waits. Items never
// overlap: a new value is taken only in idle. A stalled receiver holds the
// character in the output register and pauses emission; the next value is
// taken while the last character still waits there.
// Reset returns the block to idle, drops m_valid and restores the register.
module decimal_ascii_formatter #(
    parameter int MAX_DIGITS = 10
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [3:0] cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_cmd,
    input  logic [31:0] s_value,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [5:0] m_ascii_char,
    output logic       m_last
);
    import daf_pkg::*;

    // Number of digit cells, and so the largest number of characters.
    localparam int LIM = (MAX_DIGITS > DIGIT_CAP) ? DIGIT_CAP : MAX_DIGITS;
    // Width of a digit count from 0 to LIM.
    localparam int CW  = $clog2(LIM + 1);

    daf_state_t     state_reg, state_next;
    logic [31:0]    value_reg, value_next;
    logic [4:0]     bit_cnt_reg, bit_cnt_next;
    logic           ovf_reg, ovf_next;
    logic           mode_reg, mode_next;
    logic [CW-1:0]  sig_reg, sig_next;
    logic [CW-1:0]  pad_reg, pad_next;
    logic [3:0]     fw_reg;
    logic           m_valid_reg, m_valid_next;
    logic [5:0]     m_char_reg, m_char_next;
    logic           m_last_reg, m_last_next;

    daf_cell_ctrl_t cell_ctrl;
    logic [LIM:0]   carry;
    logic [3:0]     digit [LIM];
    logic [3:0]     top_digit;

    logic [CW-1:0]  width_eff;
    logic [CW-1:0]  sig_eff;
    logic [CW-1:0]  pad_calc;
    logic           out_free;

    // The row of digit cells. Cell 0 holds the least significant digit and
    // takes the value bits; carries and digits both move toward the top.
    assign carry[0] = value_reg[31];
    generate
        for (genvar i = 0; i < LIM; i++) begin : g_cell
            logic [3:0] dig_low;
            if (i == 0) begin : g_bottom
                assign dig_low = 4'd0;
            end else begin : g_upper
                assign dig_low = digit[i-1];
            end
            daf_cell u_cell (
                .aclk     (aclk),
                .ctrl     (cell_ctrl),
                .bit_in   (carry[i]),
                .digit_in (dig_low),
                .bit_out  (carry[i+1]),
                .digit    (digit[i])
            );
        end
    endgenerate

    assign top_digit = digit[LIM-1];

    // Fraction width saturates at the number of cells.
    assign width_eff = (fw_reg > LIM) ? CW'(LIM) : CW'(fw_reg);
    // In integer mode a value of zero still prints one digit.
    assign sig_eff   = (mode_reg == MODE_INT && sig_reg == '0) ? CW'(1) : sig_reg;
    assign pad_calc  = (mode_reg == MODE_FRAC && width_eff > sig_eff) ?
                       width_eff - sig_eff : '0;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        value_next   = value_reg;
        bit_cnt_next = bit_cnt_reg;
        ovf_next     = ovf_reg;
        mode_next    = mode_reg;
        sig_next     = sig_reg;
        pad_next     = pad_reg;
        m_valid_next = m_valid_reg;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        cell_ctrl    = '0;

        // The receiver took the waiting character.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    value_next      = s_value;
                    mode_next       = s_cmd;
                    bit_cnt_next    = '0;
                    ovf_next        = 1'b0;
                    sig_next        = CW'(LIM);
                    cell_ctrl.clear = 1'b1;
                    state_next      = ST_CONV;
                end
            end
            ST_CONV: begin
                // One value bit enters the bottom cell per cycle. A carry out
                // of the top cell means the value has more digits than cells.
                cell_ctrl.dbl = 1'b1;
                value_next    = {value_reg[30:0], 1'b0};
                ovf_next      = ovf_reg | carry[LIM];
                bit_cnt_next  = bit_cnt_reg + 5'd1;
                if (bit_cnt_reg == 5'd31) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Strip leading zero digits by moving the row up one digit
                // per cycle; an overflowed value keeps all its cells.
                if (ovf_reg || top_digit != 4'd0 || sig_reg == '0) begin
                    sig_next = sig_eff;
                    pad_next = pad_calc;
                    if (sig_eff == '0 && pad_calc == '0) begin
                        // Zero value in fraction mode with zero width.
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end else begin
                    cell_ctrl.dig_shift = 1'b1;
                    sig_next            = sig_reg - CW'(1);
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (pad_reg != '0) begin
                        m_char_next = ASCII_ZERO;
                        m_last_next = (pad_reg == CW'(1)) && (sig_reg == '0);
                        pad_next    = pad_reg - CW'(1);
                        if (m_last_next) begin
                            state_next = ST_IDLE;
                        end
                    end else begin
                        m_char_next         = ASCII_ZERO + {2'b00, top_digit};
                        m_last_next         = (sig_reg == CW'(1));
                        sig_next            = sig_reg - CW'(1);
                        cell_ctrl.dig_shift = 1'b1;
                        if (m_last_next) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            fw_reg      <= 4'd3;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                fw_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        value_reg   <= value_next;
        bit_cnt_reg <= bit_cnt_next;
        ovf_reg     <= ovf_next;
        mode_reg    <= mode_next;
        sig_reg     <= sig_next;
        pad_reg     <= pad_next;
        m_char_reg  <= m_char_next;
        m_last_reg  <= m_last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_ascii_char = m_char_reg;
    assign m_last       = m_last_reg;

    // Every character is a decimal digit from '0' to '9'.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_ascii_char >= ASCII_ZERO && m_ascii_char <= ASCII_ZERO + 6'd9))
        else $error("result character is not a decimal digit");

    // Emission never starts or continues with nothing left to print.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT |-> (pad_reg != '0 || sig_reg != '0))
        else $error("emit state with empty character count");

    // The digit count never exceeds the number of cells.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE && state_reg != ST_CONV |-> sig_reg <= CW'(LIM))
        else $error("digit count above cell count");

    // A conversion hands over to the scan only after the bit counter reaches its last bit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && $past(state_reg) == ST_CONV) |-> $past(bit_cnt_reg) == 5'd31)
        else $error("conversion left early or late");

endmodule

/* hw/rtl/daf_cell.sv */
module daf_cell (
    input  logic                    aclk,
    input  daf_pkg::daf_cell_ctrl_t ctrl,
    input  logic                    bit_in,
    input  logic [3:0]              digit_in,
    output logic                    bit_out,
    output logic [3:0]              digit
);
    import daf_pkg::*;

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adj;

    // A digit of five or more overflows when doubled, so add three first.
    assign adj     = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
    assign bit_out = adj[3];
    assign digit   = digit_reg;

    always_comb begin
        digit_next = digit_reg;
        if (ctrl.clear) begin
            digit_next = 4'd0;
        end else if (ctrl.dbl) begin
            digit_next = {adj[2:0], bit_in};
        end else if (ctrl.dig_shift) begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge aclk) begin
        digit_reg <= digit_next;
    end

endmodule
